// ----- rtl/sre_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sre_pkg
// Shared types, widths and helpers for the symbol run block extractor.
// ----------------------------------------------------------------------------
package sre_pkg;

    localparam int NUM_TYPES = 16;
    localparam int TYPE_W    = 4;
    localparam int CNT_W     = 16;
    localparam int FIFO_D    = 4;
    localparam int FIFO_AW   = 2;

    localparam logic [CNT_W-1:0] CNT_LIMIT = '1;
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    // a run that just closed
    typedef struct packed {
        logic              vld;
        logic [TYPE_W-1:0] typ;
        logic [CNT_W-1:0]  len;
        logic [CNT_W-1:0]  start;
    } t_close;

    // one output word
    typedef struct packed {
        logic [TYPE_W-1:0] typ;
        logic [CNT_W-1:0]  len;
        logic [CNT_W-1:0]  start;
        logic [CNT_W-1:0]  occ;
        logic [CNT_W-1:0]  max_runs;
        logic              last;
    } t_rec;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (v == CNT_LIMIT) ? v : v + CNT_ONE;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/sre_type_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sre_type_lane
// Per-type run counters: runs in the current chain and the greatest
// runs-per-chain seen so far.
// ----------------------------------------------------------------------------
module sre_type_lane (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_inc,
    input  wire logic                      i_clear,
    output logic [sre_pkg::CNT_W-1:0]      o_occ,
    output logic [sre_pkg::CNT_W-1:0]      o_max_nxt
);
    import sre_pkg::*;

    logic [CNT_W-1:0] r_cnt;
    logic [CNT_W-1:0] r_max;
    logic [CNT_W-1:0] n_cnt;
    logic [CNT_W-1:0] n_max;
    logic [CNT_W-1:0] w_cnt_inc;

    always_comb begin
        w_cnt_inc = sat_inc(r_cnt);
        n_cnt     = r_cnt;
        n_max     = r_max;
        if (i_inc) begin
            n_cnt = w_cnt_inc;
            if (r_max < w_cnt_inc) begin
                n_max = w_cnt_inc;
            end
        end
        // chain done: the run count restarts for the next chain; the maximum is kept
        if (i_clear) begin
            n_cnt = '0;
        end
    end

    assign o_occ     = r_cnt;
    assign o_max_nxt = n_max;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_max <= '0;
        end else begin
            r_cnt <= n_cnt;
            r_max <= n_max;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sre_run_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sre_run_ctrl
// Tracks the open run and chain position; reports up to two closed runs
// per monomer (run ended by a type change, then the flushed final run).
// ----------------------------------------------------------------------------
module sre_run_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_fire,
    input  wire logic [sre_pkg::TYPE_W-1:0]    i_type,
    input  wire logic                          i_end,
    input  wire logic [sre_pkg::NUM_TYPES-1:0] i_mask,
    output sre_pkg::t_close                    o_close1,
    output sre_pkg::t_close                    o_close2
);
    import sre_pkg::*;

    logic              r_in_chain;
    logic [TYPE_W-1:0] r_run_type;
    logic [CNT_W-1:0]  r_run_len;
    logic [CNT_W-1:0]  r_run_start;
    logic [CNT_W-1:0]  r_pos;

    logic              n_in_chain;
    logic [TYPE_W-1:0] n_run_type;
    logic [CNT_W-1:0]  n_run_len;
    logic [CNT_W-1:0]  n_run_start;
    logic [CNT_W-1:0]  n_pos;
    logic [CNT_W-1:0]  w_pos_inc;
    t_close            w_c1;
    t_close            w_c2;

    always_comb begin
        w_pos_inc   = sat_inc(r_pos);
        w_c1        = '0;
        w_c2        = '0;
        n_in_chain  = r_in_chain;
        n_run_type  = r_run_type;
        n_run_len   = r_run_len;
        n_run_start = r_run_start;
        n_pos       = r_pos;

        if (!r_in_chain) begin
            n_in_chain  = 1'b1;
            n_run_type  = i_type;
            n_run_len   = CNT_ONE;
            n_run_start = CNT_ONE;
            n_pos       = CNT_ONE;
        end else begin
            n_pos = w_pos_inc;
            if (i_type == r_run_type) begin
                n_run_len = sat_inc(r_run_len);
            end else begin
                w_c1.vld    = i_fire && i_mask[r_run_type];
                w_c1.typ    = r_run_type;
                w_c1.len    = r_run_len;
                w_c1.start  = r_run_start;
                n_run_type  = i_type;
                n_run_len   = CNT_ONE;
                n_run_start = w_pos_inc;
            end
        end

        // flush the run that this monomer leaves open
        w_c2.vld   = i_fire && i_end && i_mask[n_run_type];
        w_c2.typ   = n_run_type;
        w_c2.len   = n_run_len;
        w_c2.start = n_run_start;

        if (i_end) begin
            n_in_chain  = 1'b0;
            n_run_type  = '0;
            n_run_len   = '0;
            n_run_start = '0;
            n_pos       = '0;
        end
    end

    assign o_close1 = w_c1;
    assign o_close2 = w_c2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_chain  <= 1'b0;
            r_run_type  <= '0;
            r_run_len   <= '0;
            r_run_start <= '0;
            r_pos       <= '0;
        end else if (i_fire) begin
            r_in_chain  <= n_in_chain;
            r_run_type  <= n_run_type;
            r_run_len   <= n_run_len;
            r_run_start <= n_run_start;
            r_pos       <= n_pos;
        end
    end

endmodule
`default_nettype wire

// ----- rtl/sre_out_fifo.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// sre_out_fifo
// Small output queue taking up to two words per cycle, one out per cycle.
// ----------------------------------------------------------------------------
module sre_out_fifo (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_push0,
    input  wire sre_pkg::t_rec               i_data0,
    input  wire logic                        i_push1,
    input  wire sre_pkg::t_rec               i_data1,
    input  wire logic                        i_pop,
    output sre_pkg::t_rec                    o_head,
    output logic                             o_valid,
    output logic [sre_pkg::FIFO_AW:0]        o_count
);
    import sre_pkg::*;

    t_rec               r_mem [FIFO_D];
    logic [FIFO_AW-1:0] r_wr_ptr;
    logic [FIFO_AW-1:0] r_rd_ptr;
    logic [FIFO_AW:0]   r_cnt;
    logic [FIFO_AW:0]   n_cnt;
    logic [FIFO_AW-1:0] w_wr_ptr1;
    logic               w_pop;

    assign w_pop     = i_pop && (r_cnt != '0);
    assign w_wr_ptr1 = r_wr_ptr + FIFO_AW'(1);

    always_comb begin
        n_cnt = r_cnt + (FIFO_AW+1)'(i_push0) + (FIFO_AW+1)'(i_push1)
              - (FIFO_AW+1)'(w_pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push0) begin
            r_mem[r_wr_ptr] <= i_data0;
        end
        if (i_push1) begin
            r_mem[w_wr_ptr1] <= i_data1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_AW'(i_push0) + FIFO_AW'(i_push1);
            r_rd_ptr <= r_rd_ptr + FIFO_AW'(w_pop);
            r_cnt    <= n_cnt;
        end
    end

    assign o_head  = r_mem[r_rd_ptr];
    assign o_valid = (r_cnt != '0);
    assign o_count = r_cnt;

endmodule
`default_nettype wire

// ----- rtl/symbol_run_block_extractor.sv -----
`default_nettype none
// Path: a taken monomer waits in the input register until the output queue has
//   room for two words, then the run/counter update writes the output queue.
// Throughput: one monomer per cycle while unstalled and each yields at most one
//   word; a chain end closing two runs gives two; output is one word per cycle.
// Reset (synchronous, active low) clears run state, all per-type counters,
//   the mask and the output queue; no clearing pass, ready at once.
// ----------------------------------------------------------------------------
// symbol_run_block_extractor
// Run-length block extractor for monomer chains with per-type run counts.
// ----------------------------------------------------------------------------
module symbol_run_block_extractor (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_stall,
    input  wire logic [sre_pkg::TYPE_W-1:0]   i_monomer_type,
    input  wire logic                         i_chain_end,
    output logic                              o_out_valid,
    input  wire logic                         i_out_stall,
    output logic [sre_pkg::TYPE_W-1:0]        o_block_type,
    output logic [sre_pkg::CNT_W-1:0]         o_block_length,
    output logic [sre_pkg::CNT_W-1:0]         o_block_start,
    output logic [sre_pkg::CNT_W-1:0]         o_occurrence_number,
    output logic [sre_pkg::CNT_W-1:0]         o_type_max_runs,
    output logic                              o_last_of_item,
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [sre_pkg::NUM_TYPES-1:0] i_cfg_data
);
    import sre_pkg::*;

    logic                 r_in_vld;
    logic [TYPE_W-1:0]    r_in_type;
    logic                 r_in_end;
    logic [NUM_TYPES-1:0] r_mask;

    logic                 w_fire;
    logic                 w_take;
    logic [FIFO_AW:0]     w_fifo_cnt;
    t_close               w_c1;
    t_close               w_c2;
    t_rec                 w_rec1;
    t_rec                 w_rec2;
    t_rec                 w_head;
    logic [CNT_W-1:0]     w_occ     [NUM_TYPES];
    logic [CNT_W-1:0]     w_max_nxt [NUM_TYPES];
    logic [NUM_TYPES-1:0] w_inc;

    // queue must hold both words an item may produce
    assign w_fire     = r_in_vld && (w_fifo_cnt <= (FIFO_AW+1)'(FIFO_D - 2));
    assign o_in_stall = r_in_vld && !w_fire;
    assign w_take     = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_take) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_in_type <= i_monomer_type;
            r_in_end  <= i_chain_end;
        end
    end

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_mask <= i_cfg_data;
        end
    end

    sre_run_ctrl u_run (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_fire),
        .i_type   (r_in_type),
        .i_end    (r_in_end),
        .i_mask   (r_mask),
        .o_close1 (w_c1),
        .o_close2 (w_c2)
    );

    for (genvar k = 0; k < NUM_TYPES; k++) begin : g_lane
        assign w_inc[k] = (w_c1.vld && (w_c1.typ == TYPE_W'(k)))
                       || (w_c2.vld && (w_c2.typ == TYPE_W'(k)));

        sre_type_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_inc     (w_inc[k]),
            .i_clear   (w_fire && r_in_end),
            .o_occ     (w_occ[k]),
            .o_max_nxt (w_max_nxt[k])
        );
    end

    always_comb begin
        w_rec1.typ      = w_c1.typ;
        w_rec1.len      = w_c1.len;
        w_rec1.start    = w_c1.start;
        w_rec1.occ      = w_occ[w_c1.typ];
        w_rec1.max_runs = w_max_nxt[w_c1.typ];
        w_rec1.last     = !w_c2.vld;

        w_rec2.typ      = w_c2.typ;
        w_rec2.len      = w_c2.len;
        w_rec2.start    = w_c2.start;
        w_rec2.occ      = w_occ[w_c2.typ];
        w_rec2.max_runs = w_max_nxt[w_c2.typ];
        w_rec2.last     = 1'b1;
    end

    sre_out_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push0 (w_c1.vld || w_c2.vld),
        .i_data0 (w_c1.vld ? w_rec1 : w_rec2),
        .i_push1 (w_c1.vld && w_c2.vld),
        .i_data1 (w_rec2),
        .i_pop   (o_out_valid && !i_out_stall),
        .o_head  (w_head),
        .o_valid (o_out_valid),
        .o_count (w_fifo_cnt)
    );

    assign o_block_type        = w_head.typ;
    assign o_block_length      = w_head.len;
    assign o_block_start       = w_head.start;
    assign o_occurrence_number = w_head.occ;
    assign o_type_max_runs     = w_head.max_runs;
    assign o_last_of_item      = w_head.last;

`ifndef SYNTH
    a_fifo_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fifo_cnt <= (FIFO_AW+1)'(FIFO_D))
        else $error("output queue overflow");

    a_two_types: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_c1.vld && w_c2.vld) |-> (w_c1.typ != w_c2.typ))
        else $error("two closed runs of one type");

    a_close_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_c1.vld || w_c2.vld) |-> w_fire)
        else $error("run closed without a processed monomer");

    a_hold_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_fire) |=> (r_in_vld && $stable(r_in_type) && $stable(r_in_end)))
        else $error("held monomer lost");
`endif

endmodule
`default_nettype wire
